FILE: hdl/slrgb_pkg.sv
// shared types and constants for the scan line to rgb888 unpacker
// used by slrgb_front, slrgb_fifo, slrgb_back and the core top level
// no dependencies
package slrgb_pkg;

    localparam int BYTE_W   = 8;
    localparam int FMT_W    = 2;
    localparam int LINE_W   = 16;
    localparam int WIDTH_W  = 14;
    localparam int HEIGHT_W = 16;
    localparam int POS_W    = 19;

    localparam logic [FMT_W-1:0] FMT_RGB  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_GRAY = 2'd1;
    localparam logic [FMT_W-1:0] FMT_MONO = 2'd2;

    localparam logic [1:0] REG_FORMAT     = 2'd0;
    localparam logic [1:0] REG_LINE_BYTES = 2'd1;
    localparam logic [1:0] REG_WIDTH      = 2'd2;
    localparam logic [1:0] REG_HEIGHT     = 2'd3;

    localparam logic REQ_DATA  = 1'b0;
    localparam logic REQ_START = 1'b1;

    localparam logic [BYTE_W-1:0] MONO_BLACK = 8'h00;
    localparam logic [BYTE_W-1:0] MONO_WHITE = 8'hff;
    localparam logic [BYTE_W-1:0] MONO_MSB   = 8'h80;

    typedef enum logic [2:0] {
        KIND_START,
        KIND_RGB,
        KIND_GRAY,
        KIND_MONO,
        KIND_DROP
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
    } item_t;

    typedef struct packed {
        logic [FMT_W-1:0]    format;
        logic [LINE_W-1:0]   line_bytes;
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
    } cfg_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] row;
        logic [WIDTH_W-1:0]  column;
        logic [BYTE_W-1:0]   red;
        logic [BYTE_W-1:0]   green;
        logic [BYTE_W-1:0]   blue;
    } pix_t;

endpackage

FILE: hdl/slrgb_front.sv
// input side of the unpacker: takes beats and classifies them by request and format
// depends on slrgb_pkg; feeds slrgb_fifo
module slrgb_front
    import slrgb_pkg::*;
(
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              req_type,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [FMT_W-1:0]  frame_format,
    input  logic              queue_full,
    output logic              push,
    output item_t             item
);

    kind_t kind;

    always_comb
    begin
        if (req_type == REQ_START)
        begin
            kind = KIND_START;
        end
        else
        begin
            unique case (frame_format)
                FMT_RGB:  kind = KIND_RGB;
                FMT_GRAY: kind = KIND_GRAY;
                FMT_MONO: kind = KIND_MONO;
                default:  kind = KIND_DROP;
            endcase
        end
    end

    assign in_ready  = !queue_full;
    assign push      = in_valid && !queue_full;
    assign item.kind = kind;
    assign item.data = data_byte;

endmodule

FILE: hdl/slrgb_fifo.sv
// small queue of classified items between the front and back ends
// depends on slrgb_pkg for the item type
module slrgb_fifo
    import slrgb_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  item_t                      push_item,
    input  logic                       pop,
    output logic                       full,
    output logic                       head_valid,
    output item_t                      head_item,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(DEPTH);

    item_t             mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]  level_reg, level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign full       = (level_reg == FULL_LVL);
    assign head_valid = (level_reg != '0);
    assign head_item  = mem[rd_ptr_reg];
    assign level      = level_reg;

endmodule

FILE: hdl/slrgb_back.sv
// back end of the unpacker: line and row counters, pixel assembly, mono bit loop,
// one-pixel hold for the last flag and the output register; depends on slrgb_pkg
module slrgb_back
    import slrgb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  item_valid,
    input  item_t item,
    output logic  item_pop,
    output logic  out_valid,
    input  logic  out_ready,
    output pix_t  out_pix,
    output logic  out_last
);

    logic                frame_active_reg, frame_active_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [WIDTH_W-1:0]  pix_idx_reg, pix_idx_next;
    logic [1:0]          phase_reg, phase_next;
    logic [15:0]         held_reg, held_next;
    logic [2:0]          bit_reg, bit_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                pend_final_reg, pend_final_next;
    pix_t                pend_pix_reg, pend_pix_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_last_reg, out_last_next;
    pix_t                out_pix_reg, out_pix_next;

    logic                go;
    logic                work;
    logic                active;
    logic [POS_W-1:0]    pos_inc;
    logic [POS_W-1:0]    line_len;
    logic                wrap;
    logic [HEIGHT_W-1:0] row_inc;
    logic [15:0]         width3;
    logic                new_pix;
    logic                item_end;
    logic                rel;
    pix_t                new_px;
    logic [BYTE_W-1:0]   mono_val;

    assign go       = !out_valid_reg || out_ready;
    assign work     = item_valid && go;
    assign active   = frame_active_reg && (row_reg < cfg.height);
    assign pos_inc  = pos_reg + 1'b1;
    assign line_len = (item.kind == KIND_MONO) ? {cfg.line_bytes, 3'b000}
                                               : {3'b000, cfg.line_bytes};
    assign wrap     = (pos_inc >= line_len);
    assign row_inc  = row_reg + 1'b1;
    assign width3   = {1'b0, cfg.width, 1'b0} + {2'b00, cfg.width};
    assign mono_val = ((item.data & (MONO_MSB >> bit_reg)) != '0) ? MONO_BLACK : MONO_WHITE;

    always_comb
    begin
        frame_active_next = frame_active_reg;
        row_next          = row_reg;
        pos_next          = pos_reg;
        pix_idx_next      = pix_idx_reg;
        phase_next        = phase_reg;
        held_next         = held_reg;
        bit_next          = bit_reg;
        new_pix           = 1'b0;
        item_end          = 1'b0;
        new_px            = '0;
        new_px.row        = row_reg;

        if (work)
        begin
            item_end = 1'b1;
            unique case (item.kind)
                KIND_START:
                begin
                    frame_active_next = 1'b1;
                    row_next          = '0;
                    pos_next          = '0;
                    pix_idx_next      = '0;
                    phase_next        = '0;
                    held_next         = '0;
                    bit_next          = '0;
                end
                KIND_RGB:
                begin
                    if (active)
                    begin
                        if (pos_reg < {3'b000, width3})
                        begin
                            case (phase_reg)
                                2'd0:
                                begin
                                    held_next  = {item.data, 8'h00};
                                    phase_next = 2'd1;
                                end
                                2'd1:
                                begin
                                    held_next  = {held_reg[15:8], item.data};
                                    phase_next = 2'd2;
                                end
                                default:
                                begin
                                    new_pix       = 1'b1;
                                    new_px.column = pix_idx_reg;
                                    new_px.red    = held_reg[15:8];
                                    new_px.green  = held_reg[7:0];
                                    new_px.blue   = item.data;
                                    pix_idx_next  = pix_idx_reg + 1'b1;
                                    phase_next    = 2'd0;
                                end
                            endcase
                        end
                        if (wrap)
                        begin
                            row_next     = row_inc;
                            pos_next     = '0;
                            pix_idx_next = '0;
                            phase_next   = '0;
                        end
                        else
                        begin
                            pos_next = pos_inc;
                        end
                    end
                end
                KIND_GRAY:
                begin
                    if (active)
                    begin
                        if (pos_reg < {5'b00000, cfg.width})
                        begin
                            new_pix       = 1'b1;
                            new_px.column = pos_reg[WIDTH_W-1:0];
                            new_px.red    = item.data;
                            new_px.green  = item.data;
                            new_px.blue   = item.data;
                        end
                        if (wrap)
                        begin
                            row_next     = row_inc;
                            pos_next     = '0;
                            pix_idx_next = '0;
                            phase_next   = '0;
                        end
                        else
                        begin
                            pos_next = pos_inc;
                        end
                    end
                end
                KIND_MONO:
                begin
                    if (active)
                    begin
                        if (pos_reg < {5'b00000, cfg.width})
                        begin
                            new_pix       = 1'b1;
                            new_px.column = pos_reg[WIDTH_W-1:0];
                            new_px.red    = mono_val;
                            new_px.green  = mono_val;
                            new_px.blue   = mono_val;
                        end
                        if (wrap)
                        begin
                            row_next     = row_inc;
                            pos_next     = '0;
                            pix_idx_next = '0;
                            phase_next   = '0;
                        end
                        else
                        begin
                            pos_next = pos_inc;
                        end
                        // frame done mid byte drops the remaining bits
                        item_end = (bit_reg == 3'd7) || (wrap && (row_inc >= cfg.height));
                        bit_next = item_end ? 3'd0 : bit_reg + 1'b1;
                    end
                end
                default:
                begin
                    item_end = 1'b1;
                end
            endcase
        end
    end

    // hold the newest pixel until the next one or the end of its byte sets its last flag
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_final_next = pend_final_reg;
        pend_pix_next   = pend_pix_reg;
        out_valid_next  = out_valid_reg;
        out_last_next   = out_last_reg;
        out_pix_next    = out_pix_reg;
        rel             = pend_valid_reg && (new_pix || item_end || pend_final_reg);
        if (go)
        begin
            out_valid_next = rel;
            if (rel)
            begin
                out_pix_next  = pend_pix_reg;
                out_last_next = pend_final_reg || (item_end && !new_pix);
            end
            if (new_pix)
            begin
                pend_valid_next = 1'b1;
                pend_final_next = item_end;
                pend_pix_next   = new_px;
            end
            else if (rel)
            begin
                pend_valid_next = 1'b0;
                pend_final_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_active_reg <= 1'b0;
            row_reg          <= '0;
            pos_reg          <= '0;
            pix_idx_reg      <= '0;
            phase_reg        <= '0;
            held_reg         <= '0;
            bit_reg          <= '0;
            pend_valid_reg   <= 1'b0;
            pend_final_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            frame_active_reg <= frame_active_next;
            row_reg          <= row_next;
            pos_reg          <= pos_next;
            pix_idx_reg      <= pix_idx_next;
            phase_reg        <= phase_next;
            held_reg         <= held_next;
            bit_reg          <= bit_next;
            pend_valid_reg   <= pend_valid_next;
            pend_final_reg   <= pend_final_next;
            out_valid_reg    <= out_valid_next;
            out_last_reg     <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_pix_reg <= pend_pix_next;
        out_pix_reg  <= out_pix_next;
    end

    assign item_pop  = work && item_end;
    assign out_valid = out_valid_reg;
    assign out_pix   = out_pix_reg;
    assign out_last  = out_last_reg;

endmodule

FILE: hdl/scan_line_to_rgb888_unpacker_core.sv
// Scan line to RGB888 unpacker. Raw scanner bytes come in on the slave stream and
// RGB888 pixels tagged with row and column leave on the master stream. A front end
// classifies each beat (start request, RGB, gray or mono byte, or dropped) into a
// QUEUE_DEPTH-entry queue; the back end holds the line and row counters and builds
// pixels. The back end takes an RGB or gray byte whole and works a mono byte one bit
// per cycle while the output does not stall, ending early when the frame ends inside
// it; the queue keeps accepting a byte every cycle until it is full.
// A built pixel is held one stage until its last flag is known: an RGB or gray pixel
// goes to the hold register and then the output register once its byte reaches the
// head of the queue, a mono pixel once its bit is taken, or later when only padding bits
// follow it, since it then waits for the end of its byte. tlast marks the final pixel
// of each byte. Registers on the APB port at byte addresses 0, 4, 8, 12: frame format,
// source line bytes, image width, image height; write them only while the block is idle.
// depends on slrgb_pkg, slrgb_front, slrgb_fifo, slrgb_back
module scan_line_to_rgb888_unpacker_core
    import slrgb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_row[15:0], pixel_column[29:16], red[37:30], green[45:38], blue[53:46], zero pad
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tlast    // last_of_item
);

    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    logic [FMT_W-1:0]    format_reg;
    logic [LINE_W-1:0]   line_bytes_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic                cfg_write;
    cfg_t                cfg;

    logic                q_full;
    logic                q_push;
    item_t               q_in_item;
    logic                q_valid;
    item_t               q_head;
    logic                q_pop;
    logic [LVL_W-1:0]    q_level;
    pix_t                out_pix;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg     <= FMT_RGB;
            line_bytes_reg <= 16'd1;
            width_reg      <= 14'd1;
            height_reg     <= 16'd1;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_FORMAT:     format_reg     <= pwdata[FMT_W-1:0];
                REG_LINE_BYTES: line_bytes_reg <= pwdata[LINE_W-1:0];
                REG_WIDTH:      width_reg      <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT:     height_reg     <= pwdata[HEIGHT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_FORMAT:     prdata = {30'd0, format_reg};
            REG_LINE_BYTES: prdata = {16'd0, line_bytes_reg};
            REG_WIDTH:      prdata = {18'd0, width_reg};
            REG_HEIGHT:     prdata = {16'd0, height_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.format     = format_reg;
    assign cfg.line_bytes = line_bytes_reg;
    assign cfg.width      = width_reg;
    assign cfg.height     = height_reg;

    slrgb_front u_front
    (
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .req_type     (s_axis_tuser),
        .data_byte    (s_axis_tdata),
        .frame_format (format_reg),
        .queue_full   (q_full),
        .push         (q_push),
        .item         (q_in_item)
    );

    slrgb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_in_item),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_item  (q_head),
        .level      (q_level)
    );

    slrgb_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (q_valid),
        .item       (q_head),
        .item_pop   (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_pix    (out_pix),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_pix.blue, out_pix.green, out_pix.red,
                           out_pix.column, out_pix.row};

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= LVL_W'(QUEUE_DEPTH))
        else $error("queue level beyond depth");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (q_level != '0))
        else $error("accepted beat missing from queue");

endmodule

FILE: sim/slrgb_pixel_checker.sv
// pixel checker for the scan line to rgb888 unpacker: follows apb writes and both streams,
// predicts the pixels of each accepted input beat and compares output beats in order
// depends on slrgb_pkg
module slrgb_pixel_checker
    import slrgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pixels_pending,
    output int          pixels_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [HEIGHT_W-1:0] row;
        logic [WIDTH_W-1:0]  column;
        logic [BYTE_W-1:0]   red;
        logic [BYTE_W-1:0]   green;
        logic [BYTE_W-1:0]   blue;
        logic                last;
    } rgb_pixel_t;

    logic [FMT_W-1:0]    cfg_format;
    logic [LINE_W-1:0]   cfg_line;
    logic [WIDTH_W-1:0]  cfg_width;
    logic [HEIGHT_W-1:0] cfg_height;

    logic                frame_on;
    logic [HEIGHT_W-1:0] row_cnt;
    logic [POS_W-1:0]    line_pos;
    logic [WIDTH_W-1:0]  rgb_col;
    logic [1:0]          chan_phase;
    logic [15:0]         held_rg;

    rgb_pixel_t expected_pixels[$];
    rgb_pixel_t want_pixel;

    initial
    begin
        fail_count = 0;
        pixels_checked = 0;
        pixels_pending = 0;
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %s: got 0x%0h, want 0x%0h at %0t", field, got, want, $time);
        fail_count++;
    endtask

    function automatic rgb_pixel_t make_pixel(input logic [WIDTH_W-1:0] col,
                                              input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
        rgb_pixel_t p;
        p.row = row_cnt;
        p.column = col;
        p.red = r;
        p.green = g;
        p.blue = b;
        p.last = 1'b0;
        return p;
    endfunction

    // step one position along the line, returns 1 when the last row is done
    function automatic logic next_position(input int unsigned limit);
        line_pos = line_pos + 1'b1;
        if ({13'd0, line_pos} >= limit)
        begin
            row_cnt = row_cnt + 1'b1;
            line_pos = '0;
            rgb_col = '0;
            chan_phase = '0;
            return row_cnt >= cfg_height;
        end
        return 1'b0;
    endfunction

    task automatic unpack_byte(input logic req, input logic [7:0] d);
        rgb_pixel_t made [0:7];
        int n;
        int b;
        logic [7:0] shade;
        n = 0;
        if (req == REQ_START)
        begin
            frame_on = 1'b1;
            row_cnt = '0;
            line_pos = '0;
            rgb_col = '0;
            chan_phase = '0;
            held_rg = '0;
            return;
        end
        if (!frame_on || row_cnt >= cfg_height)
            return;
        case (cfg_format)
            FMT_RGB:
            begin
                if (line_pos < 3 * cfg_width)
                begin
                    if (chan_phase == 2'd0)
                    begin
                        held_rg = {d, 8'h00};
                        chan_phase = 2'd1;
                    end
                    else if (chan_phase == 2'd1)
                    begin
                        held_rg[7:0] = d;
                        chan_phase = 2'd2;
                    end
                    else
                    begin
                        made[n] = make_pixel(rgb_col, held_rg[15:8], held_rg[7:0], d);
                        n++;
                        rgb_col = rgb_col + 1'b1;
                        chan_phase = 2'd0;
                    end
                end
                void'(next_position(cfg_line));
            end
            FMT_GRAY:
            begin
                if (line_pos < cfg_width)
                begin
                    made[n] = make_pixel(line_pos[WIDTH_W-1:0], d, d, d);
                    n++;
                end
                void'(next_position(cfg_line));
            end
            FMT_MONO:
            begin
                for (b = 0; b < 8; b++)
                begin
                    if (line_pos < cfg_width)
                    begin
                        shade = ((d & (MONO_MSB >> b)) != 0) ? MONO_BLACK : MONO_WHITE;
                        made[n] = make_pixel(line_pos[WIDTH_W-1:0], shade, shade, shade);
                        n++;
                    end
                    if (next_position(cfg_line * 8))
                        break;
                end
            end
            default:
                return;
        endcase
        if (n > 0)
            made[n-1].last = 1'b1;
        for (b = 0; b < n; b++)
            expected_pixels.push_back(made[b]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_format = FMT_RGB;
            cfg_line = 16'd1;
            cfg_width = 14'd1;
            cfg_height = 16'd1;
            frame_on = 1'b0;
            row_cnt = '0;
            line_pos = '0;
            rgb_col = '0;
            chan_phase = '0;
            held_rg = '0;
            expected_pixels.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_FORMAT:     cfg_format = pwdata[FMT_W-1:0];
                    REG_LINE_BYTES: cfg_line = pwdata[LINE_W-1:0];
                    REG_WIDTH:      cfg_width = pwdata[WIDTH_W-1:0];
                    REG_HEIGHT:     cfg_height = pwdata[HEIGHT_W-1:0];
                    default:        ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                unpack_byte(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch("pixel beat with nothing expected", m_axis_tdata[31:0], 0);
                else
                begin
                    want_pixel = expected_pixels.pop_front();
                    pixels_checked++;
                    if (m_axis_tdata[15:0] !== want_pixel.row)
                        report_mismatch("pixel_row", m_axis_tdata[15:0], want_pixel.row);
                    if (m_axis_tdata[29:16] !== want_pixel.column)
                        report_mismatch("pixel_column", m_axis_tdata[29:16], want_pixel.column);
                    if (m_axis_tdata[37:30] !== want_pixel.red)
                        report_mismatch("red", m_axis_tdata[37:30], want_pixel.red);
                    if (m_axis_tdata[45:38] !== want_pixel.green)
                        report_mismatch("green", m_axis_tdata[45:38], want_pixel.green);
                    if (m_axis_tdata[53:46] !== want_pixel.blue)
                        report_mismatch("blue", m_axis_tdata[53:46], want_pixel.blue);
                    if (m_axis_tlast !== want_pixel.last)
                        report_mismatch("last_of_item", m_axis_tlast, want_pixel.last);
                end
            end
        end
        pixels_pending = expected_pixels.size();
    end

endmodule

FILE: sim/tb_scan_line_to_rgb888_unpacker_core.sv
// testbench top for scan_line_to_rgb888_unpacker_core: clock, reset, apb setup and
// byte stimulus with random idling and back pressure; the pixel checker gives the verdict data
// depends on slrgb_pkg, slrgb_pixel_checker and the unpacker rtl
module tb_scan_line_to_rgb888_unpacker_core;
    timeunit 1ns;
    timeprecision 1ps;
    import slrgb_pkg::*;

    localparam logic [FMT_W-1:0] FMT_UNKNOWN = 2'd3;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 200;
    localparam int RANDOM_BYTES  = 140;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = REQ_DATA;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;

    int fail_count;
    int pixels_pending;
    int pixels_checked;

    int send_idle_pct = 30;
    int recv_idle_pct = 77;
    int hold_req_cnt = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int frame_bytes_sent = 0;

    scan_line_to_rgb888_unpacker_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    slrgb_pixel_checker pixel_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .fail_count     (fail_count),
        .pixels_pending (pixels_pending),
        .pixels_checked (pixels_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_scan_line_to_rgb888_unpacker_core: FAIL");
        $finish;
    end

    // pixel receiver: random stalls plus an occasional long hold
    always @(posedge clk)
    begin
        if (hold_seen != hold_req_cnt)
        begin
            hold_seen = hold_req_cnt;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_byte(input logic req, input logic [7:0] value);
        int gap;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= value;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // sender pauses until every pixel is out and the block has gone quiet
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pixels_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_format(input logic [1:0] fmt, input int line, input int width,
                               input int height);
        drain_block();
        apb_write(REG_FORMAT, {30'd0, fmt});
        apb_write(REG_LINE_BYTES, line);
        apb_write(REG_WIDTH, width);
        apb_write(REG_HEIGHT, height);
    endtask

    function automatic logic [7:0] random_byte();
        logic [7:0] b;
        case ($urandom_range(7))
            0:       b = 8'h00;
            1:       b = 8'hff;
            default: b = 8'($urandom_range(255));
        endcase
        return b;
    endfunction

    initial
    begin
        int fmt;
        int line;
        int width;
        int height;
        int nbytes;
        int cut;
        int i;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: beats before any start are dropped, then a one byte frame
        send_byte(REQ_DATA, 8'h00);
        send_byte(REQ_START, 8'hff);
        send_byte(REQ_DATA, 8'h5a);
        send_byte(REQ_DATA, 8'ha5);

        // rgb pixel followed by a padding byte
        load_format(FMT_RGB, 4, 1, 1);
        send_byte(REQ_START, 8'h00);
        send_byte(REQ_DATA, 8'hff);
        send_byte(REQ_DATA, 8'h00);
        send_byte(REQ_DATA, 8'h80);
        send_byte(REQ_DATA, 8'h7f);

        // short line drops a half built rgb pixel
        load_format(FMT_RGB, 2, 5, 1);
        send_byte(REQ_START, 8'h00);
        send_byte(REQ_DATA, 8'h12);
        send_byte(REQ_DATA, 8'h34);

        load_format(FMT_GRAY, 3, 2, 1);
        send_byte(REQ_START, 8'h00);
        send_byte(REQ_DATA, 8'h00);
        send_byte(REQ_DATA, 8'hff);
        send_byte(REQ_DATA, 8'h55);

        // mono with padding bits in the second byte
        load_format(FMT_MONO, 2, 12, 1);
        send_byte(REQ_START, 8'h00);
        send_byte(REQ_DATA, 8'h80);
        send_byte(REQ_DATA, 8'h7f);

        // zero line length, height reached inside a mono byte
        load_format(FMT_MONO, 0, 5, 3);
        send_byte(REQ_START, 8'h00);
        send_byte(REQ_DATA, 8'ha5);

        // zero width
        load_format(FMT_GRAY, 2, 0, 1);
        send_byte(REQ_START, 8'h00);
        send_byte(REQ_DATA, 8'hc3);
        send_byte(REQ_DATA, 8'h3c);

        load_format(FMT_UNKNOWN, 4, 4, 4);
        send_byte(REQ_START, 8'h00);
        send_byte(REQ_DATA, 8'h99);

        load_format(FMT_GRAY, 65535, 16383, 65535);
        send_byte(REQ_START, 8'h00);
        send_byte(REQ_DATA, 8'h01);
        send_byte(REQ_DATA, 8'hfe);

        // long receiver hold while the sender keeps offering mono bytes
        load_format(FMT_MONO, 3, 20, 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req_cnt++;
        send_byte(REQ_START, 8'h00);
        for (i = 0; i < 9; i++)
            send_byte(REQ_DATA, random_byte());

        while (frame_bytes_sent < RANDOM_BYTES)
        begin
            if (frame_bytes_sent < RANDOM_BYTES / 3)
            begin
                send_idle_pct = 30;
                recv_idle_pct = 77;
            end
            else if (frame_bytes_sent < 2 * RANDOM_BYTES / 3)
            begin
                send_idle_pct = 77;
                recv_idle_pct = 30;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            fmt = $urandom_range(2);
            height = $urandom_range(1, 3);
            case (fmt)
                FMT_RGB:
                begin
                    line = $urandom_range(1, 12);
                    width = $urandom_range(1, 5);
                end
                FMT_GRAY:
                begin
                    line = $urandom_range(1, 10);
                    width = $urandom_range(1, line + 2);
                end
                default:
                begin
                    line = $urandom_range(1, 3);
                    width = $urandom_range(1, line * 8 + 4);
                end
            endcase
            if ($urandom_range(15) == 0)
                line = 0;
            if (line == 0)
                nbytes = (fmt == FMT_MONO) ? (height + 7) / 8 : height;
            else
                nbytes = height * line;
            load_format(2'(fmt), line, width, height);
            repeat ($urandom_range(1, 3))
            begin
                send_byte(REQ_START, random_byte());
                // some frames are cut short by the next start
                cut = ($urandom_range(9) == 0) ? $urandom_range(0, nbytes - 1) : nbytes;
                for (i = 0; i < cut; i++)
                begin
                    send_byte(REQ_DATA, random_byte());
                    frame_bytes_sent++;
                end
                repeat ($urandom_range(0, 2)) send_byte(REQ_DATA, random_byte());
            end
        end

        drain_block();
        $display("random frames carried %0d data bytes; %0d pixels compared in total",
                 frame_bytes_sent, pixels_checked);
        $display("directed beats covered padding, short and zero line length, zero width, "
                 , "unknown format and extreme register values");
        if (fail_count == 0 && pixels_pending == 0)
            $display("tb_scan_line_to_rgb888_unpacker_core: PASS");
        else
            $display("tb_scan_line_to_rgb888_unpacker_core: FAIL");
        $finish;
    end

endmodule
